// ----- design/vpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vpp_pkg;

	// Camera depth stays below 2^34 in magnitude, so 37 bits hold it signed.
	localparam int ZW = 37;
	localparam int QW = 32;
	localparam int SW = 50;

	typedef enum logic [3:0] {
		REG_ROT0    = 4'd0,
		REG_ROT1    = 4'd1,
		REG_ROT2    = 4'd2,
		REG_TRANSXY = 4'd3,
		REG_TRANSZ  = 4'd4,
		REG_FOCAL   = 4'd5,
		REG_SCALE   = 4'd6,
		REG_CENTER  = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic [47:0] rot0;
		logic [47:0] rot1;
		logic [47:0] rot2;
		logic [63:0] trans_xy;
		logic [31:0] trans_z;
		logic [31:0] focal;
		logic [31:0] scale;
		logic [31:0] center;
	} vpp_cfg_t;

	typedef struct packed {
		logic signed [31:0] xc;
		logic signed [31:0] yc;
		logic [ZW-1:0]      zmag;
		logic               zero;
		logic               fneg;
		logic               sat;
	} vpp_cam_t;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(SW-32){1'b0}}, 32'h7FFFFFFF})) begin
			r = 32'sh7FFFFFFF;
		end else if (v < $signed({{(SW-32){1'b1}}, 32'h80000000})) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/vpp_view.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpp_view (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire vpp_pkg::vpp_cfg_t     cfg,
	input  wire logic signed [31:0]    pos_x,
	input  wire logic signed [31:0]    pos_y,
	input  wire logic signed [31:0]    pos_z,
	output logic                       out_valid,
	output vpp_pkg::vpp_cam_t          cam
);
	import vpp_pkg::*;

	logic [47:0]        rows [3];
	logic signed [31:0] coords [3];
	logic signed [47:0] prod_s1 [9];
	logic               vld_s1, vld_s2, vld_s3;
	logic signed [31:0] x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	vpp_cam_t           cam_s3;

	assign rows[0] = cfg.rot0;
	assign rows[1] = cfg.rot1;
	assign rows[2] = cfg.rot2;
	assign coords[0] = pos_x;
	assign coords[1] = pos_y;
	assign coords[2] = pos_z;

	// Nine 16x32 products, one per matrix entry.
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s1[3*r+c] <= $signed(rows[r][16*c +: 16]) * coords[c];
				end
			end
		end
	end

	// Row sums, rounding half up from Q.30 to Q16.16, then translation.
	logic signed [SW-1:0] sum [3];
	logic signed [SW-1:0] rnd [3];
	logic signed [ZW-1:0] cc [3];
	logic signed [31:0]   tr [3];

	assign tr[0] = cfg.trans_xy[31:0];
	assign tr[1] = cfg.trans_xy[63:32];
	assign tr[2] = cfg.trans_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SW'(prod_s1[3*r]) + SW'(prod_s1[3*r+1]) + SW'(prod_s1[3*r+2]);
			rnd[r] = (sum[r] + SW'(8192)) >>> 14;
			cc[r]  = rnd[r][ZW-1:0] + ZW'(tr[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= sat32(SW'(cc[0]));
			y_s2 <= sat32(SW'(cc[1]));
			z_s2 <= cc[2];
		end
	end

	// Depth magnitude, zero test and factor overflow test.
	logic [ZW-1:0] zmag;
	assign zmag = z_s2[ZW-1] ? ZW'(-z_s2) : ZW'(z_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			cam_s3.xc   <= x_s2;
			cam_s3.yc   <= y_s2;
			cam_s3.zmag <= zmag;
			cam_s3.zero <= (z_s2 == '0);
			cam_s3.fneg <= z_s2[ZW-1];
			cam_s3.sat  <= (z_s2 != '0) && (ZW'(cfg.focal[31:16]) >= zmag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid = vld_s3;
	assign cam       = cam_s3;
endmodule
`default_nettype wire

// ----- design/vpp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpp_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [31:0]       focal,
	input  wire logic              in_valid,
	input  wire vpp_pkg::vpp_cam_t in_cam,
	output logic                   out_valid,
	output vpp_pkg::vpp_cam_t      out_cam,
	output logic [31:0]            quot
);
	import vpp_pkg::*;

	// One quotient bit per stage, most significant first, of focal * 2^16 / zmag.
	logic [ZW-1:0] rem_s [QW+1];
	logic [QW-1:0] quot_s [QW+1];
	vpp_cam_t      cam_s [QW+1];
	logic          vld_s [QW+1];

	assign rem_s[0]  = ZW'(focal[31:16]);
	assign quot_s[0] = '0;
	assign cam_s[0]  = in_cam;
	assign vld_s[0]  = in_valid;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic          dbit;
		logic [ZW:0]   trial;
		logic [ZW:0]   diff;
		logic          take;

		if (K >= 16) begin : g_hi
			assign dbit = focal[K-16];
		end else begin : g_lo
			assign dbit = 1'b0;
		end

		assign trial = {rem_s[j], dbit};
		assign diff  = trial - {1'b0, cam_s[j].zmag};
		assign take  = (trial >= {1'b0, cam_s[j].zmag});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? diff[ZW-1:0] : trial[ZW-1:0];
				quot_s[j+1] <= {quot_s[j][QW-2:0], take};
				cam_s[j+1]  <= cam_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_cam   = cam_s[QW];
	assign quot      = quot_s[QW];
endmodule
`default_nettype wire

// ----- design/vpp_proj.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vpp_proj (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire vpp_pkg::vpp_cfg_t cfg,
	input  wire logic              in_valid,
	input  wire vpp_pkg::vpp_cam_t cam,
	input  wire logic [31:0]       quot,
	output logic                   out_valid,
	output logic signed [31:0]     screen_x,
	output logic signed [31:0]     screen_y
);
	import vpp_pkg::*;

	logic [31:0] fmag;
	logic        fn;
	logic [32:0] negx, negy;
	logic [31:0] cmag_x, cmag_y;
	logic [63:0] px_s1, py_s1;
	logic        nx_s1, ny_s1, vld_s1, vld_s2;
	logic signed [31:0] sx_s2, sy_s2;

	always_comb begin
		if (cam.zero) begin
			fmag = cfg.scale;
		end else if (cam.sat) begin
			fmag = '1;
		end else begin
			fmag = quot;
		end
		fn     = cam.fneg && !cam.zero;
		negx   = -{cam.xc[31], cam.xc};
		negy   = -{cam.yc[31], cam.yc};
		cmag_x = cam.xc[31] ? negx[31:0] : cam.xc;
		cmag_y = cam.yc[31] ? negy[31:0] : cam.yc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= cmag_x * fmag;
			py_s1 <= cmag_y * fmag;
			nx_s1 <= cam.xc[31] != fn;
			ny_s1 <= cam.yc[31] != fn;
		end
	end

	// Round the magnitude half away from zero, apply sign, add the center.
	function automatic logic signed [31:0] finish(input logic [63:0] p, input logic neg,
			input logic [15:0] half);
		logic [63:0]          t;
		logic signed [SW-1:0] v;
		logic signed [SW-1:0] s;
		t = p + 64'h8000;
		v = $signed({2'b00, t[63:16]});
		if (neg) begin
			v = -v;
		end
		s = v + $signed({{(SW-32){1'b0}}, half, 16'h0000});
		return sat32(s);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= finish(px_s1, nx_s1, cfg.center[15:0]);
			sy_s2 <= finish(py_s1, ny_s1, cfg.center[31:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	assign out_valid = vld_s2;
	assign screen_x  = sx_s2;
	assign screen_y  = sy_s2;
endmodule
`default_nettype wire

// ----- design/vertex_perspective_projection.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Perspective projection of a stream of world points onto the screen.
// Each transfer on the slave stream carries one point (x, y, z in signed
// Q16.16); each transfer on the master stream carries the projected screen
// x and y in signed Q16.16, saturated. Points are independent, so while the
// output is not stalled one point can enter and one result leave every cycle.
// The pipeline is 37 stages deep: three stages for the view transform
// (products, row sums with rounding, depth magnitude), 32 stages of a
// restoring divider that produces one factor bit per stage, and two stages
// for the screen multiply and the final rounding and saturation.
// The whole pipeline advances together: while a result waits in the output
// register and the receiver holds tready low, every stage holds and s_tready
// drops, so nothing is lost or repeated.
// The configuration channel is always ready and writes one register per
// transfer; indexes beyond the register list are ignored. Registers are
// meant to change only while the pipeline is empty.
// Reset empties the pipeline and restores the identity view, focal and scale
// of 1.0 and a zero center.
module vertex_perspective_projection (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // screen_x [31:0], screen_y [63:32]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import vpp_pkg::*;

	vpp_cfg_t cfg_q;
	logic     en;
	logic     view_valid, div_valid, proj_valid;
	vpp_cam_t view_cam, div_cam;
	logic [31:0] div_quot;
	logic signed [31:0] sx, sy;

	// Register writes; data wider than a register is cut to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot0     <= 48'h0000_0000_4000;
			cfg_q.rot1     <= 48'h0000_4000_0000;
			cfg_q.rot2     <= 48'h4000_0000_0000;
			cfg_q.trans_xy <= '0;
			cfg_q.trans_z  <= '0;
			cfg_q.focal    <= 32'h0001_0000;
			cfg_q.scale    <= 32'h0001_0000;
			cfg_q.center   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROT0:    cfg_q.rot0     <= cfg_data[47:0];
				REG_ROT1:    cfg_q.rot1     <= cfg_data[47:0];
				REG_ROT2:    cfg_q.rot2     <= cfg_data[47:0];
				REG_TRANSXY: cfg_q.trans_xy <= cfg_data;
				REG_TRANSZ:  cfg_q.trans_z  <= cfg_data[31:0];
				REG_FOCAL:   cfg_q.focal    <= cfg_data[31:0];
				REG_SCALE:   cfg_q.scale    <= cfg_data[31:0];
				REG_CENTER:  cfg_q.center   <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the output register is empty or being taken.
	assign en       = !proj_valid || m_tready;
	assign s_tready = en;

	vpp_view u_view (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.cfg       (cfg_q),
		.pos_x     (s_tdata[31:0]),
		.pos_y     (s_tdata[63:32]),
		.pos_z     (s_tdata[95:64]),
		.out_valid (view_valid),
		.cam       (view_cam)
	);

	vpp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.focal     (cfg_q.focal),
		.in_valid  (view_valid),
		.in_cam    (view_cam),
		.out_valid (div_valid),
		.out_cam   (div_cam),
		.quot      (div_quot)
	);

	vpp_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (div_valid),
		.cam       (div_cam),
		.quot      (div_quot),
		.out_valid (proj_valid),
		.screen_x  (sx),
		.screen_y  (sy)
	);

	assign m_tvalid = proj_valid;
	assign m_tdata  = {sx, sy} == '0 ? 64'h0 : {sy, sx};

	// A zero depth never takes the saturated-factor path.
	a_zero_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		view_valid && view_cam.zero |-> !view_cam.sat)
		else $error("zero depth flagged as factor overflow");

	// A stalled output blocks new points from entering.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	// During a stall the view stage output holds.
	a_view_hold: assert property (@(posedge clk) disable iff (!arst_n)
		view_valid && !en |=> view_valid && $stable(view_cam))
		else $error("view stage changed during a stall");

	// An item leaving the divider passes the multiply and rounding registers and reaches the output without a stall.
	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && en ##1 en |=> m_tvalid)
		else $error("divider result lost before output");

endmodule
`default_nettype wire
